// File: hw/rtl/grid_box_corridor_inflation_macros.svh
// Assertion macros shared by the checker of the grid box corridor inflation block.
// Depends on nothing; every macro takes the clock and the active-low reset.
`ifndef GRID_BOX_CORRIDOR_INFLATION_MACROS_SVH
`define GRID_BOX_CORRIDOR_INFLATION_MACROS_SVH

// Holds whenever the antecedent is seen in the same cycle.
`define GBCI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Holds in the cycle after the antecedent.
`define GBCI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/gbci_pkg.sv
// Shared types and constants of the grid box corridor inflation block.
// Used by the top level and the checker; depends on nothing.
package gbci_pkg;

  localparam int MAX_COLUMNS_DEF = 512;
  localparam int MAX_ROWS_DEF    = 512;

  // The grid memory packs this many cells into one word.
  localparam int WORD_W  = 32;
  localparam int WORD_SH = 5;

  localparam logic [9:0] COLS_RST  = 10'd400;
  localparam logic [9:0] ROWS_RST  = 10'd400;
  localparam logic [7:0] LIMIT_RST = 8'd50;

  // Round after which the grown box is tested against the last box.
  localparam logic [7:0] CHECK_ROUND = 8'd3;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_INFLATE  = 2'd1,
    CMD_NEW_PATH = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_KEPT      = 3'd0,
    ST_IN_LAST   = 3'd1,
    ST_OCCUPIED  = 3'd2,
    ST_CONTAINED = 3'd3,
    ST_ACK       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_COLS  = 2'd0,
    REG_ROWS  = 2'd1,
    REG_LIMIT = 2'd2
  } reg_idx_t;

endpackage

// File: hw/rtl/gbci_ram.sv
// Generic single-port RAM with a registered read, used for the occupancy grid.
// Depends on nothing.
module gbci_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hw/rtl/grid_box_corridor_inflation.sv
// Top level of the grid box corridor inflation block: configuration registers,
// command sequencer and box growth. Depends on gbci_pkg and gbci_ram.
//
// The occupancy grid lives in one RAM of 32-cell words, MAX_ROWS rows of
// ceil(MAX_COLUMNS/32) words each. After reset a clearing pass writes every word
// once, one word per cycle, and no transaction is accepted until it ends;
// configuration writes are taken throughout. A cell write passes through S_WR_RD,
// S_WR_WB and S_DONE, and a new-path or unused command (or a write off the grid)
// goes straight to S_DONE; the input is free again as soon as S_DONE moves the
// result into the output registers. An inflate command reads and checks the seed in
// S_SEED_RD and S_SEED_CHK, then in each round visits S_SIDE for every side and,
// on a side that can still grow, S_SCAN once per grid word read on a row side or
// per cell on a column side and then S_SCAN_END, and closes the round in S_ROUND,
// over up to round_limit rounds. The single RAM port, read once per cycle, bounds
// the scans. One item is worked on at a time; the next one is taken while the last
// result still waits.
module grid_box_corridor_inflation #(
  parameter int MAX_COLUMNS = gbci_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = gbci_pkg::MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [8:0]  in_cell_col,
  input  logic [8:0]  in_cell_row,
  input  logic        in_occupied_bit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_box_col_low,
  output logic [8:0]  out_box_col_high,
  output logic [8:0]  out_box_row_low,
  output logic [8:0]  out_box_row_high,
  output logic [2:0]  out_status
);

  localparam int WW    = gbci_pkg::WORD_W;
  localparam int WS    = gbci_pkg::WORD_SH;
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int PW    = (CW > RW) ? CW : RW;
  localparam int PXW   = PW + WS;
  localparam int XW    = ((PW > 10) ? PW : 10) + 1;
  localparam int LW    = (PW > 9) ? PW : 9;
  localparam int WPR   = (MAX_COLUMNS + WW - 1) / WW;
  localparam int DEPTH = MAX_ROWS * WPR;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WR_RD, S_WR_WB, S_SEED_RD, S_SEED_CHK,
    S_SIDE, S_SCAN, S_SCAN_END, S_ROUND, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SD_ROW_UP, SD_ROW_DN, SD_COL_UP, SD_COL_DN
  } side_t;

  state_t            state_r;
  side_t             side_r;
  logic [AW-1:0]     clr_r;
  logic [9:0]        cols_r;
  logic [9:0]        rows_r;
  logic [7:0]        limit_r;
  logic [8:0]        col_r;
  logic [8:0]        row_r;
  logic              occ_r;
  logic [PW-1:0]     b_cl_r;
  logic [PW-1:0]     b_ch_r;
  logic [PW-1:0]     b_rl_r;
  logic [PW-1:0]     b_rh_r;
  logic [3:0]        hit_r;
  logic              changed_r;
  logic [7:0]        round_r;
  logic [PW-1:0]     line_r;
  logic [PW-1:0]     ptr_r;
  logic [PW-1:0]     end_r;
  logic              is_row_r;
  logic              pend_r;
  logic [WW-1:0]     mask_r;
  logic              blk_r;
  logic              lb_valid_r;
  logic [8:0]        lb_cl_r;
  logic [8:0]        lb_ch_r;
  logic [8:0]        lb_rl_r;
  logic [8:0]        lb_rh_r;
  logic [8:0]        res_cl_r;
  logic [8:0]        res_ch_r;
  logic [8:0]        res_rl_r;
  logic [8:0]        res_rh_r;
  gbci_pkg::status_t res_st_r;
  logic              out_valid_r;
  logic [8:0]        out_cl_r;
  logic [8:0]        out_ch_r;
  logic [8:0]        out_rl_r;
  logic [8:0]        out_rh_r;
  gbci_pkg::status_t out_st_r;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [WW-1:0]     ram_wdata;
  logic [WW-1:0]     ram_rdata;
  logic [PW-1:0]     arow;
  logic [PW-1:0]     awidx;
  logic [PW-1:0]     wm1;
  logic [PW-1:0]     hm1;
  logic [WS-1:0]     seed_bit;
  logic [WS-1:0]     line_bit;
  logic [WW-1:0]     row_mask;
  logic [PXW-1:0]    pos;
  logic              blocked;
  logic              seed_in_last;
  logic              seed_off_map;
  logic              grown_in_last;
  logic              wr_in_grid;
  logic              need_scan;
  logic [PW-1:0]     side_line;
  logic              accept;
  logic              out_free;

  assign pready   = 1'b1;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    unique case (paddr[3:2])
      gbci_pkg::REG_COLS:  prdata = 32'(cols_r);
      gbci_pkg::REG_ROWS:  prdata = 32'(rows_r);
      gbci_pkg::REG_LIMIT: prdata = 32'(limit_r);
      default:             prdata = '0;
    endcase
  end

  // Map in use, as highest column and row index.
  always_comb begin
    if (cols_r == 10'd0) begin
      wm1 = '0;
    end else if (XW'(cols_r) >= XW'(MAX_COLUMNS)) begin
      wm1 = PW'(MAX_COLUMNS - 1);
    end else begin
      wm1 = PW'(cols_r - 10'd1);
    end
    if (rows_r == 10'd0) begin
      hm1 = '0;
    end else if (XW'(rows_r) >= XW'(MAX_ROWS)) begin
      hm1 = PW'(MAX_ROWS - 1);
    end else begin
      hm1 = PW'(rows_r - 10'd1);
    end
  end

  assign seed_bit  = WS'(col_r % WW);
  assign line_bit  = WS'(line_r % WW);
  assign wr_in_grid = (XW'(in_cell_col) < XW'(MAX_COLUMNS)) &&
                      (XW'(in_cell_row) < XW'(MAX_ROWS));
  assign seed_in_last = lb_valid_r && (lb_cl_r <= col_r) && (lb_ch_r >= col_r) &&
                        (lb_rl_r <= row_r) && (lb_rh_r >= row_r);
  assign seed_off_map = (XW'(col_r) > XW'(wm1)) || (XW'(row_r) > XW'(hm1));
  assign grown_in_last = lb_valid_r &&
                         (LW'(lb_cl_r) <= LW'(b_cl_r)) && (LW'(lb_ch_r) >= LW'(b_ch_r)) &&
                         (LW'(lb_rl_r) <= LW'(b_rl_r)) && (LW'(lb_rh_r) >= LW'(b_rh_r));
  assign blocked = blk_r || (pend_r && ((ram_rdata & mask_r) != '0));

  always_comb begin
    pos = '0;
    for (int j = 0; j < WW; j++) begin
      pos = (PXW'(ptr_r) << WS) | PXW'(j);
      row_mask[j] = (pos >= PXW'(b_cl_r)) && (pos <= PXW'(b_ch_r));
    end
  end

  always_comb begin
    unique case (side_r)
      SD_ROW_UP: begin
        need_scan = !hit_r[side_r] && (b_rh_r < hm1);
        side_line = b_rh_r + PW'(1);
      end
      SD_ROW_DN: begin
        need_scan = !hit_r[side_r] && (b_rl_r != '0);
        side_line = b_rl_r - PW'(1);
      end
      SD_COL_UP: begin
        need_scan = !hit_r[side_r] && (b_ch_r < wm1);
        side_line = b_ch_r + PW'(1);
      end
      SD_COL_DN: begin
        need_scan = !hit_r[side_r] && (b_cl_r != '0);
        side_line = b_cl_r - PW'(1);
      end
      default: begin
        need_scan = 1'b0;
        side_line = '0;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    arow      = PW'(row_r);
    awidx     = PW'(col_r / WW);
    unique case (state_r)
      S_WR_WB: begin
        ram_we = 1'b1;
        ram_wdata[seed_bit] = occ_r;
      end
      S_SCAN: begin
        if (is_row_r) begin
          arow  = line_r;
          awidx = ptr_r;
        end else begin
          arow  = ptr_r;
          awidx = PW'(line_r / WW);
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      default: begin
      end
    endcase
    if (state_r == S_CLEAR) begin
      ram_addr = clr_r;
    end else begin
      ram_addr = AW'(AW'(arow) * AW'(WPR) + AW'(awidx));
    end
  end

  gbci_ram #(
    .WIDTH(WW),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= gbci_pkg::COLS_RST;
      rows_r  <= gbci_pkg::ROWS_RST;
      limit_r <= gbci_pkg::LIMIT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        gbci_pkg::REG_COLS:  cols_r  <= pwdata[9:0];
        gbci_pkg::REG_ROWS:  rows_r  <= pwdata[9:0];
        gbci_pkg::REG_LIMIT: limit_r <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      lb_valid_r  <= 1'b0;
      lb_cl_r     <= '0;
      lb_ch_r     <= '0;
      lb_rl_r     <= '0;
      lb_rh_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      side_r      <= SD_ROW_UP;
    end else begin
      pend_r <= (state_r == S_SCAN);
      if (state_r == S_SIDE) begin
        blk_r <= 1'b0;
      end else if (pend_r) begin
        blk_r <= blocked;
      end
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            col_r    <= in_cell_col;
            row_r    <= in_cell_row;
            occ_r    <= in_occupied_bit;
            res_cl_r <= '0;
            res_ch_r <= '0;
            res_rl_r <= '0;
            res_rh_r <= '0;
            res_st_r <= gbci_pkg::ST_ACK;
            unique case (in_command)
              gbci_pkg::CMD_WRITE:   state_r <= wr_in_grid ? S_WR_RD : S_DONE;
              gbci_pkg::CMD_INFLATE: state_r <= S_SEED_RD;
              gbci_pkg::CMD_NEW_PATH: begin
                lb_valid_r <= 1'b0;
                state_r    <= S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_WR_RD: state_r <= S_WR_WB;
        S_WR_WB: state_r <= S_DONE;
        S_SEED_RD: begin
          if (seed_in_last) begin
            res_cl_r <= lb_cl_r;
            res_ch_r <= lb_ch_r;
            res_rl_r <= lb_rl_r;
            res_rh_r <= lb_rh_r;
            res_st_r <= gbci_pkg::ST_IN_LAST;
            state_r  <= S_DONE;
          end else if (seed_off_map) begin
            res_cl_r <= col_r;
            res_ch_r <= col_r;
            res_rl_r <= row_r;
            res_rh_r <= row_r;
            res_st_r <= gbci_pkg::ST_OCCUPIED;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_SEED_CHK;
          end
        end
        S_SEED_CHK: begin
          b_cl_r    <= PW'(col_r);
          b_ch_r    <= PW'(col_r);
          b_rl_r    <= PW'(row_r);
          b_rh_r    <= PW'(row_r);
          hit_r     <= '0;
          changed_r <= 1'b0;
          round_r   <= '0;
          side_r    <= SD_ROW_UP;
          if (ram_rdata[seed_bit]) begin
            res_cl_r <= col_r;
            res_ch_r <= col_r;
            res_rl_r <= row_r;
            res_rh_r <= row_r;
            res_st_r <= gbci_pkg::ST_OCCUPIED;
            state_r  <= S_DONE;
          end else if (limit_r == 8'd0) begin
            res_cl_r   <= col_r;
            res_ch_r   <= col_r;
            res_rl_r   <= row_r;
            res_rh_r   <= row_r;
            res_st_r   <= gbci_pkg::ST_KEPT;
            lb_cl_r    <= col_r;
            lb_ch_r    <= col_r;
            lb_rl_r    <= row_r;
            lb_rh_r    <= row_r;
            lb_valid_r <= 1'b1;
            state_r    <= S_DONE;
          end else begin
            state_r <= S_SIDE;
          end
        end
        S_SIDE: begin
          line_r <= side_line;
          if (side_r == SD_ROW_UP || side_r == SD_ROW_DN) begin
            is_row_r <= 1'b1;
            ptr_r    <= PW'(b_cl_r / WW);
            end_r    <= PW'(b_ch_r / WW);
          end else begin
            is_row_r <= 1'b0;
            ptr_r    <= b_rl_r;
            end_r    <= b_rh_r;
          end
          if (need_scan) begin
            state_r <= S_SCAN;
          end else if (side_r == SD_COL_DN) begin
            state_r <= S_ROUND;
          end else begin
            side_r <= side_t'(side_r + 2'd1);
          end
        end
        S_SCAN: begin
          mask_r <= is_row_r ? row_mask : (WW'(1) << line_bit);
          ptr_r  <= ptr_r + PW'(1);
          if (ptr_r == end_r) begin
            state_r <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          if (blocked) begin
            hit_r[side_r] <= 1'b1;
          end else begin
            changed_r <= 1'b1;
            unique case (side_r)
              SD_ROW_UP: b_rh_r <= line_r;
              SD_ROW_DN: b_rl_r <= line_r;
              SD_COL_UP: b_ch_r <= line_r;
              SD_COL_DN: b_cl_r <= line_r;
              default: begin
              end
            endcase
          end
          if (side_r == SD_COL_DN) begin
            state_r <= S_ROUND;
          end else begin
            side_r  <= side_t'(side_r + 2'd1);
            state_r <= S_SIDE;
          end
        end
        S_ROUND: begin
          if (changed_r && round_r == gbci_pkg::CHECK_ROUND && grown_in_last) begin
            res_cl_r <= lb_cl_r;
            res_ch_r <= lb_ch_r;
            res_rl_r <= lb_rl_r;
            res_rh_r <= lb_rh_r;
            res_st_r <= gbci_pkg::ST_CONTAINED;
            state_r  <= S_DONE;
          end else if (!changed_r || (round_r + 8'd1) == limit_r) begin
            res_cl_r   <= 9'(b_cl_r);
            res_ch_r   <= 9'(b_ch_r);
            res_rl_r   <= 9'(b_rl_r);
            res_rh_r   <= 9'(b_rh_r);
            res_st_r   <= gbci_pkg::ST_KEPT;
            lb_cl_r    <= 9'(b_cl_r);
            lb_ch_r    <= 9'(b_ch_r);
            lb_rl_r    <= 9'(b_rl_r);
            lb_rh_r    <= 9'(b_rh_r);
            lb_valid_r <= 1'b1;
            state_r    <= S_DONE;
          end else begin
            round_r   <= round_r + 8'd1;
            changed_r <= 1'b0;
            side_r    <= SD_ROW_UP;
            state_r   <= S_SIDE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_cl_r    <= res_cl_r;
            out_ch_r    <= res_ch_r;
            out_rl_r    <= res_rl_r;
            out_rh_r    <= res_rh_r;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_box_col_low  = out_cl_r;
  assign out_box_col_high = out_ch_r;
  assign out_box_row_low  = out_rl_r;
  assign out_box_row_high = out_rh_r;
  assign out_status       = out_st_r;

endmodule

// File: hw/rtl/gbci_checker.sv
// Port-level checker of the grid box corridor inflation block, bound to the top level.
// Depends on gbci_pkg and the block's assertion macro header.
`include "grid_box_corridor_inflation_macros.svh"

module gbci_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [8:0] out_box_col_low,
  input logic [8:0] out_box_col_high,
  input logic [8:0] out_box_row_low,
  input logic [8:0] out_box_row_high,
  input logic [2:0] out_status
);

  `GBCI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_box_col_low) && $stable(out_box_col_high) && $stable(out_box_row_low) && $stable(out_box_row_high) && $stable(out_status), "Stalled result transaction changed.")
  `GBCI_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "Input accepted while a transaction was in progress.")
  `GBCI_ASSERT_NOW(a_ack_zero_box, clk, rst_n, out_valid && out_status == gbci_pkg::ST_ACK, out_box_col_low == 9'd0 && out_box_col_high == 9'd0 && out_box_row_low == 9'd0 && out_box_row_high == 9'd0, "Acknowledged transaction carries a nonzero box.")
  `GBCI_ASSERT_NOW(a_occupied_one_cell, clk, rst_n, out_valid && out_status == gbci_pkg::ST_OCCUPIED, out_box_col_low == out_box_col_high && out_box_row_low == out_box_row_high, "Occupied seed reported with a box larger than one cell.")

endmodule

bind grid_box_corridor_inflation gbci_checker u_gbci_checker (.*);

// File: sim/gbci_checker.sv
// Checker for the grid box corridor inflation block: watches both channels and the
// register port, predicts each result from its own grid and box state, and counts mismatches.
// Depends on gbci_pkg.
`timescale 1ns / 100ps

module gbci_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [8:0]  in_cell_col,
  input  logic [8:0]  in_cell_row,
  input  logic        in_occupied_bit,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [8:0]  out_box_col_low,
  input  logic [8:0]  out_box_col_high,
  input  logic [8:0]  out_box_row_low,
  input  logic [8:0]  out_box_row_high,
  input  logic [2:0]  out_status,
  output int          fail_count,
  output int          pending_boxes
);

  typedef struct packed {
    logic [8:0]        col_lo;
    logic [8:0]        col_hi;
    logic [8:0]        row_lo;
    logic [8:0]        row_hi;
    gbci_pkg::status_t status;
  } box_result_t;

  bit          grid [512][512];
  bit          last_valid;
  int          last_cl, last_ch, last_rl, last_rh;
  logic [9:0]  map_cols;
  logic [9:0]  map_rows;
  logic [7:0]  rounds;
  box_result_t expected_boxes [$];

  function automatic bit last_holds(int cl, int ch, int rl, int rh);
    return last_cl <= cl && last_ch >= ch && last_rl <= rl && last_rh >= rh;
  endfunction

  function automatic bit span_blocked(bit along_row, int fixed, int a, int b);
    for (int j = a; j <= b; j++) begin
      if (along_row && grid[fixed][j]) return 1;
      if (!along_row && grid[j][fixed]) return 1;
    end
    return 0;
  endfunction

  function automatic box_result_t grow_box(int c, int r);
    box_result_t res;
    int w, h, cl, ch, rl, rh, pcl, pch, prl, prh, lu, ll, lcu, lcl;
    bit have_prev, hru, hrl, hcu, hcl;
    w = (map_cols < 1) ? 1 : (map_cols > 512 ? 512 : map_cols);
    h = (map_rows < 1) ? 1 : (map_rows > 512 ? 512 : map_rows);
    have_prev = 0; hru = 0; hrl = 0; hcu = 0; hcl = 0;
    cl = c; ch = c; rl = r; rh = r;
    pcl = 0; pch = 0; prl = 0; prh = 0;
    res.col_lo = 9'(last_cl); res.col_hi = 9'(last_ch);
    res.row_lo = 9'(last_rl); res.row_hi = 9'(last_rh);
    if (last_valid && last_holds(c, c, r, r)) begin
      res.status = gbci_pkg::ST_IN_LAST;
      return res;
    end
    if (c >= w || r >= h || grid[r][c]) begin
      res = '{9'(c), 9'(c), 9'(r), 9'(r), gbci_pkg::ST_OCCUPIED};
      return res;
    end
    for (int it = 0; it < rounds; it++) begin
      lcu = (c + it + 1 > w - 1) ? w - 1 : c + it + 1;
      lcl = (c - it - 1 < 0) ? 0 : c - it - 1;
      lu = (r + it + 1 > h - 1) ? h - 1 : r + it + 1;
      ll = (r - it - 1 < 0) ? 0 : r - it - 1;
      if (!hru) begin
        for (int i = rh + 1; i <= lu; i++) if (span_blocked(1, i, cl, ch)) hru = 1;
        rh = hru ? lu - 1 : lu;
      end
      if (!hrl) begin
        for (int i = rl - 1; i >= ll; i--) if (span_blocked(1, i, cl, ch)) hrl = 1;
        rl = hrl ? ll + 1 : ll;
      end
      if (!hcu) begin
        for (int i = ch + 1; i <= lcu; i++) if (span_blocked(0, i, rl, rh)) hcu = 1;
        ch = hcu ? lcu - 1 : lcu;
      end
      if (!hcl) begin
        for (int i = cl - 1; i >= lcl; i--) if (span_blocked(0, i, rl, rh)) hcl = 1;
        cl = hcl ? lcl + 1 : lcl;
      end
      if (have_prev && pcl == cl && pch == ch && prl == rl && prh == rh) break;
      pcl = cl; pch = ch; prl = rl; prh = rh;
      have_prev = 1;
      if (it == gbci_pkg::CHECK_ROUND && last_valid && last_holds(cl, ch, rl, rh)) begin
        res.status = gbci_pkg::ST_CONTAINED;
        return res;
      end
    end
    last_cl = cl & 511; last_ch = ch & 511; last_rl = rl & 511; last_rh = rh & 511;
    last_valid = 1;
    res = '{9'(cl), 9'(ch), 9'(rl), 9'(rh), gbci_pkg::ST_KEPT};
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: box result mismatch on %s: got %0d, expected %0d", $realtime, what, got,
             want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    box_result_t res, want;
    if (!rst_n) begin
      foreach (grid[i, j]) grid[i][j] = 0;
      last_valid = 0;
      last_cl = 0; last_ch = 0; last_rl = 0; last_rh = 0;
      map_cols = gbci_pkg::COLS_RST;
      map_rows = gbci_pkg::ROWS_RST;
      rounds = gbci_pkg::LIMIT_RST;
      expected_boxes.delete();
      pending_boxes = 0;
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          gbci_pkg::REG_COLS:  map_cols = pwdata[9:0];
          gbci_pkg::REG_ROWS:  map_rows = pwdata[9:0];
          gbci_pkg::REG_LIMIT: rounds = pwdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        res = '{9'd0, 9'd0, 9'd0, 9'd0, gbci_pkg::ST_ACK};
        case (gbci_pkg::cmd_t'(in_command))
          gbci_pkg::CMD_WRITE:    grid[in_cell_row][in_cell_col] = in_occupied_bit;
          gbci_pkg::CMD_INFLATE:  res = grow_box(in_cell_col, in_cell_row);
          gbci_pkg::CMD_NEW_PATH: last_valid = 0;
          default: ;
        endcase
        expected_boxes = {expected_boxes, res};
      end
      if (out_valid && !out_stall) begin
        if (expected_boxes.size() == 0) begin
          report_mismatch("unexpected transaction", out_status, -1);
        end else begin
          want = expected_boxes.pop_front();
          if (out_box_col_low != want.col_lo)
            report_mismatch("col_low", out_box_col_low, want.col_lo);
          if (out_box_col_high != want.col_hi)
            report_mismatch("col_high", out_box_col_high, want.col_hi);
          if (out_box_row_low != want.row_lo)
            report_mismatch("row_low", out_box_row_low, want.row_lo);
          if (out_box_row_high != want.row_hi)
            report_mismatch("row_high", out_box_row_high, want.row_hi);
          if (out_status != want.status)
            report_mismatch("status", out_status, want.status);
        end
      end
      pending_boxes = expected_boxes.size();
    end
  end
endmodule

// File: sim/grid_box_corridor_inflation_test.sv
// Top of the grid box corridor inflation testbench: clock, reset, register writes and
// command stimulus under several idling phases. Depends on gbci_pkg, gbci_scoreboard and the block.
`timescale 1ns / 100ps

module grid_box_corridor_inflation_test;

  localparam longint CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid, in_stall;
  logic [1:0]  in_command;
  logic [8:0]  in_cell_col, in_cell_row;
  logic        in_occupied_bit;
  logic        out_valid, out_stall;
  logic [8:0]  out_box_col_low, out_box_col_high, out_box_row_low, out_box_row_high;
  logic [2:0]  out_status;
  int          fail_count, pending_boxes;
  int          send_idle_pct, stall_pct;
  bit          hold_off;
  longint      cycle_count;

  grid_box_corridor_inflation DUT (.*);

  gbci_scoreboard u_scoreboard (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("** grid_box_corridor_inflation: FAILED **");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 0;
    else out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  task automatic write_register(gbci_pkg::reg_idx_t idx, int value);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // The valid line stays high after an accepted transaction until the next
  // transaction or an idle cycle replaces it.
  task automatic send_command(gbci_pkg::cmd_t cmd, int col, int row, bit occ);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd; in_cell_col <= 9'(col); in_cell_row <= 9'(row);
    in_occupied_bit <= occ;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 0;
    @(posedge clk);
    while (pending_boxes != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Random path: some obstacles near a walk of waypoints, mixed with random commands; mostly small map.
  task automatic random_path(int span);
    int c, r;
    send_command(gbci_pkg::CMD_NEW_PATH, $urandom_range(511), $urandom_range(511),
                 $urandom_range(1));
    c = $urandom_range(span - 1);
    r = $urandom_range(span - 1);
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(9))
        0, 1, 2: send_command(gbci_pkg::CMD_WRITE, $urandom_range(span - 1),
                              $urandom_range(span - 1), $urandom_range(3) != 0);
        3: send_command(gbci_pkg::cmd_t'($urandom_range(3)), $urandom_range(511),
                        $urandom_range(511), $urandom_range(1));
        default: begin
          c = (c + $urandom_range(4)) % span;
          r = (r + $urandom_range(4)) % span;
          send_command(gbci_pkg::CMD_INFLATE, c, r, $urandom_range(1));
        end
      endcase
    end
  endtask

  initial begin
    rst_n = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; in_command = gbci_pkg::CMD_WRITE; in_cell_col = 0; in_cell_row = 0;
    in_occupied_bit = 0;
    send_idle_pct = 0; stall_pct = 0; hold_off = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    write_register(gbci_pkg::REG_COLS, 24);
    write_register(gbci_pkg::REG_ROWS, 20);
    write_register(gbci_pkg::REG_LIMIT, 8);
    send_command(gbci_pkg::CMD_INFLATE, 5, 5, 0);
    send_command(gbci_pkg::CMD_INFLATE, 6, 5, 0);
    send_command(gbci_pkg::CMD_WRITE, 10, 5, 1);
    send_command(gbci_pkg::CMD_WRITE, 5, 9, 1);
    send_command(gbci_pkg::CMD_WRITE, 511, 511, 1);
    send_command(gbci_pkg::CMD_INFLATE, 10, 5, 0);
    send_command(gbci_pkg::CMD_INFLATE, 30, 3, 0);
    send_command(gbci_pkg::CMD_INFLATE, 3, 511, 0);
    send_command(gbci_pkg::CMD_NEW_PATH, 0, 0, 0);
    send_command(gbci_pkg::CMD_INFLATE, 0, 0, 1);
    send_command(gbci_pkg::CMD_INFLATE, 1, 1, 0);
    send_command(gbci_pkg::CMD_NEW_PATH, 0, 0, 0);
    send_command(gbci_pkg::CMD_INFLATE, 20, 15, 0);
    send_command(gbci_pkg::CMD_UNUSED, 511, 511, 1);
    send_command(gbci_pkg::CMD_WRITE, 10, 5, 0);
    drain_results();
    write_register(gbci_pkg::REG_LIMIT, 0);
    send_command(gbci_pkg::CMD_NEW_PATH, 0, 0, 0);
    send_command(gbci_pkg::CMD_INFLATE, 7, 7, 0);
    drain_results();
    write_register(gbci_pkg::REG_COLS, 0);
    write_register(gbci_pkg::REG_ROWS, 1023);
    write_register(gbci_pkg::REG_LIMIT, 255);
    send_command(gbci_pkg::CMD_NEW_PATH, 0, 0, 0);
    send_command(gbci_pkg::CMD_INFLATE, 0, 3, 0);
    send_command(gbci_pkg::CMD_INFLATE, 1, 3, 0);
    drain_results();
    write_register(gbci_pkg::REG_COLS, 512);
    write_register(gbci_pkg::REG_ROWS, 512);
    write_register(gbci_pkg::REG_LIMIT, 1);
    send_command(gbci_pkg::CMD_NEW_PATH, 0, 0, 0);
    send_command(gbci_pkg::CMD_INFLATE, 511, 511, 0);
    send_command(gbci_pkg::CMD_INFLATE, 500, 20, 0);
    drain_results();

    write_register(gbci_pkg::REG_COLS, 16);
    write_register(gbci_pkg::REG_ROWS, 16);
    write_register(gbci_pkg::REG_LIMIT, 6);
    hold_off <= 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off <= 0;
      end
      for (int k = 0; k < 8; k++) send_command(gbci_pkg::CMD_WRITE, k, 3, 1);
    join

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? 79 : (phase == 3 ? 33 : 0);
      stall_pct = (phase == 2) ? 79 : (phase == 3 ? 33 : 0);
      if (phase == 3) send_idle_pct = 33;
      drain_results();
      write_register(gbci_pkg::REG_COLS, $urandom_range(8, 40));
      write_register(gbci_pkg::REG_ROWS, $urandom_range(8, 40));
      write_register(gbci_pkg::REG_LIMIT, $urandom_range(2, 12));
      for (int p = 0; p < 4; p++) random_path(24);
    end
    send_idle_pct = 0; stall_pct = 0;
    drain_results();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("** grid_box_corridor_inflation: PASSED **");
    else $display("** grid_box_corridor_inflation: FAILED **");
    $finish;
  end
endmodule
